### rtl/pidc_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and saturating helpers for the PID step core.
// No dependencies; every other file in rtl/ imports this package.
package pidc_pkg;

  localparam int unsigned FIELD_W        = 32;
  localparam int unsigned STEP_W         = 31;
  localparam int unsigned WIDE_W         = 66;
  localparam int unsigned MIN_SAT_W      = 16;
  localparam int unsigned DATA_WIDTH_DEF = 32;
  localparam int unsigned FRAC_BITS_DEF  = 16;
  localparam int unsigned CFG_IDX_W      = 3;

  localparam logic signed [FIELD_W-1:0] PROP_GAIN_RST = 32'sh0001_0000;
  localparam logic        [STEP_W-1:0]  STEP_RST      = 31'd6554;
  localparam logic signed [FIELD_W-1:0] OUT_LOW_RST   = 32'sh8000_0000;
  localparam logic signed [FIELD_W-1:0] OUT_HIGH_RST  = 32'sh7fff_ffff;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROP_GAIN,
    REG_INTEG_GAIN,
    REG_DERIV_GAIN,
    REG_STEP_SECONDS,
    REG_REVERSE_ACTION,
    REG_PROP_ON_MEASURE,
    REG_OUT_LOW,
    REG_OUT_HIGH
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIFF,
    ST_NEG,
    ST_MUL_B,
    ST_MUL_A,
    ST_MUL_C,
    ST_MUL_D,
    ST_MUL_E,
    ST_WAIT_DIV,
    ST_SUM_PD,
    ST_SUM_PM,
    ST_CLAMP_I,
    ST_SUM_Y,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic                      start;
    logic signed [FIELD_W-1:0] mcand;
    logic        [FIELD_W-1:0] mplier;
  } mul_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mul_stat_t;

  // Saturate a wide signed value to a w-bit signed range, sign-extended to FIELD_W.
  function automatic logic signed [FIELD_W-1:0] sat_word(input logic signed [WIDE_W-1:0] x,
                                                         input int unsigned w);
    logic signed [WIDE_W-1:0]  hi;
    logic signed [WIDE_W-1:0]  lo;
    logic signed [FIELD_W-1:0] r;
    hi = (WIDE_W'(1) << (w - 1)) - WIDE_W'(1);
    lo = ~hi;
    if (x > hi) begin
      r = hi[FIELD_W-1:0];
    end else if (x < lo) begin
      r = lo[FIELD_W-1:0];
    end else begin
      r = x[FIELD_W-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [FIELD_W-1:0] add_sat(input logic signed [FIELD_W-1:0] a,
                                                        input logic signed [FIELD_W-1:0] b,
                                                        input int unsigned w);
    logic signed [FIELD_W:0] s;
    s = (FIELD_W+1)'(a) + (FIELD_W+1)'(b);
    return sat_word(WIDE_W'(s), w);
  endfunction

  function automatic logic signed [FIELD_W-1:0] sub_sat(input logic signed [FIELD_W-1:0] a,
                                                        input logic signed [FIELD_W-1:0] b,
                                                        input int unsigned w);
    logic signed [FIELD_W:0] s;
    s = (FIELD_W+1)'(a) - (FIELD_W+1)'(b);
    return sat_word(WIDE_W'(s), w);
  endfunction

  // When the limits cross, values below the low limit give the low limit and all others give the high limit.
  function automatic logic signed [FIELD_W-1:0] clamp_word(input logic signed [FIELD_W-1:0] x,
                                                           input logic signed [FIELD_W-1:0] lo,
                                                           input logic signed [FIELD_W-1:0] hi);
    logic signed [FIELD_W-1:0] r;
    if (x < lo) begin
      r = lo;
    end else if (hi < x) begin
      r = hi;
    end else begin
      r = x;
    end
    return r;
  endfunction

endpackage

### rtl/pidc_mul.sv
`timescale 1ns / 1ps
// Bit-serial signed shift-add multiplier, one multiplier bit per cycle.
// Result is the fixed-point product, floored and saturated. Uses pidc_pkg.
module pidc_mul #(
  parameter int unsigned FRAC_BITS = pidc_pkg::FRAC_BITS_DEF,
  parameter int unsigned SAT_W     = pidc_pkg::FIELD_W
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  pidc_pkg::mul_req_t                 req_i,
  output pidc_pkg::mul_stat_t                stat_o,
  output logic signed [pidc_pkg::FIELD_W-1:0] prod_o
);
  import pidc_pkg::*;

  localparam int unsigned CNT_W  = $clog2(FIELD_W);
  localparam int unsigned PROD_W = 2 * FIELD_W + 1;

  logic signed [FIELD_W:0]   acc_q;
  logic        [FIELD_W-1:0] lo_q;
  logic signed [FIELD_W-1:0] mcand_q;
  logic        [CNT_W-1:0]   cnt_q;
  logic                      busy_q;
  logic                      done_q;

  logic                      last;
  logic signed [FIELD_W+1:0] mcand_x;
  logic signed [FIELD_W+1:0] addend;
  logic signed [FIELD_W+1:0] sum;
  logic signed [PROD_W-1:0]  prod;
  logic signed [PROD_W-1:0]  prod_sh;

  assign last    = (cnt_q == CNT_W'(FIELD_W - 1));
  assign mcand_x = (FIELD_W+2)'(mcand_q);

  // Sign bit of the multiplier carries negative weight: subtract on the last step.
  always_comb begin
    if (lo_q[0]) begin
      addend = last ? -mcand_x : mcand_x;
    end else begin
      addend = '0;
    end
    sum = (FIELD_W+2)'(acc_q) + addend;
  end

  assign prod    = $signed({acc_q, lo_q});
  assign prod_sh = prod >>> FRAC_BITS;
  assign prod_o  = sat_word(WIDE_W'(prod_sh), SAT_W);

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (last) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start && !busy_q) begin
      acc_q   <= '0;
      lo_q    <= req_i.mplier;
      mcand_q <= req_i.mcand;
    end else if (busy_q) begin
      acc_q <= sum[FIELD_W+1:1];
      lo_q  <= {sum[0], lo_q[FIELD_W-1:1]};
    end
  end

endmodule

### rtl/pidc_div.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle: (num * 2^FRAC_BITS) / den,
// truncated toward zero and saturated. Uses pidc_pkg.
module pidc_div #(
  parameter int unsigned FRAC_BITS = pidc_pkg::FRAC_BITS_DEF,
  parameter int unsigned SAT_W     = pidc_pkg::FIELD_W
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic signed [pidc_pkg::FIELD_W-1:0] num_i,
  input  logic        [pidc_pkg::STEP_W-1:0]  den_i,
  output logic                                busy_o,
  output logic signed [pidc_pkg::FIELD_W-1:0] quot_o
);
  import pidc_pkg::*;

  localparam int unsigned N     = FIELD_W + FRAC_BITS;
  localparam int unsigned CNT_W = $clog2(N);

  logic        [STEP_W-1:0] rem_q;
  logic        [N-1:0]      dq_q;
  logic        [STEP_W-1:0] den_q;
  logic                     neg_q;
  logic        [CNT_W-1:0]  cnt_q;
  logic                     busy_q;

  logic        [FIELD_W-1:0] mag;
  logic        [FIELD_W-1:0] trial;
  logic        [FIELD_W:0]   diff;
  logic                      ge;
  logic signed [N:0]         qpos;
  logic signed [N:0]         qs;

  assign mag   = num_i[FIELD_W-1] ? (~num_i + FIELD_W'(1)) : num_i;
  assign trial = {rem_q, dq_q[N-1]};
  assign diff  = {1'b0, trial} - {2'b00, den_q};
  assign ge    = ~diff[FIELD_W];

  assign qpos   = $signed({1'b0, dq_q});
  assign qs     = neg_q ? -qpos : qpos;
  assign quot_o = sat_word(WIDE_W'(qs), SAT_W);
  assign busy_o = busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(N - 1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // Quotient bits shift in where the dividend bits shift out.
  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      rem_q <= '0;
      dq_q  <= {mag, {FRAC_BITS{1'b0}}};
      den_q <= (den_i == '0) ? STEP_W'(1) : den_i;
      neg_q <= num_i[FIELD_W-1];
    end else if (busy_q) begin
      rem_q <= ge ? diff[STEP_W-1:0] : trial[STEP_W-1:0];
      dq_q  <= {dq_q[N-2:0], ge};
    end
  end

endmodule

### rtl/pid_controller_step_core.sv
`timescale 1ns / 1ps
// PID controller step core, derivative on measurement, signed fixed point.
// Depends on pidc_pkg, pidc_mul and pidc_div.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) takes one request: target_i and
//   measured_i. Output channel (out_valid_o/out_ready_i) returns drive_o.
//   Registers are written through cfg_we_i/cfg_idx_i/cfg_data_i.
// Datapath sharing:
//   All products go through one bit-serial multiplier, four per request; the
//   divider for the derivative term runs beside it. A new request is accepted
//   only once the previous result has been loaded into the output register.
// Reset:
//   Registers return to defaults (P gain 1.0, I and D gains zero, interval 6554,
//   full range clamps), the previous measurement and the integral go to zero. No
//   clearing pass; the core is ready as soon as reset is released.
// Stall:
//   The result waits in the output register while out_ready_i is low; the
//   core still accepts and works on the next request, and holds it at the
//   last step until the output register is free.
module pid_controller_step_core #(
  parameter int unsigned DATA_WIDTH = pidc_pkg::DATA_WIDTH_DEF,
  parameter int unsigned FRAC_BITS  = pidc_pkg::FRAC_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic        [pidc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic        [pidc_pkg::FIELD_W-1:0]   cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic signed [pidc_pkg::FIELD_W-1:0]   target_i,
  input  logic signed [pidc_pkg::FIELD_W-1:0]   measured_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [pidc_pkg::FIELD_W-1:0]   drive_o
);
  import pidc_pkg::*;

  localparam int unsigned SAT_W = (DATA_WIDTH > FIELD_W) ? FIELD_W :
                                  ((DATA_WIDTH < MIN_SAT_W) ? MIN_SAT_W : DATA_WIDTH);

  // Configuration
  logic signed [FIELD_W-1:0] kp_q;
  logic signed [FIELD_W-1:0] ki_q;
  logic signed [FIELD_W-1:0] kd_q;
  logic        [STEP_W-1:0]  dt_q;
  logic                      rev_q;
  logic                      pom_q;
  logic signed [FIELD_W-1:0] low_q;
  logic signed [FIELD_W-1:0] high_q;

  // Loop state
  logic signed [SAT_W-1:0]   last_q;
  logic signed [SAT_W-1:0]   integ_q;

  // Working registers
  logic signed [FIELD_W-1:0] sp_q;
  logic signed [FIELD_W-1:0] pv_q;
  logic signed [FIELD_W-1:0] err_q;
  logic signed [FIELD_W-1:0] dm_q;
  logic signed [FIELD_W-1:0] p_q;
  logic signed [FIELD_W-1:0] i1_q;
  logic signed [FIELD_W-1:0] i2_q;
  logic signed [FIELD_W-1:0] pm_q;
  logic signed [FIELD_W-1:0] y_q;
  logic signed [FIELD_W-1:0] drive_q;
  logic                      out_valid_q;
  logic                      out_valid_d;

  state_e                    state_q;
  state_e                    state_d;
  logic                      issued_q;
  logic                      issued_d;

  mul_req_t                  mul_req;
  mul_stat_t                 mul_stat;
  logic signed [FIELD_W-1:0] mul_prod;
  logic                      div_start;
  logic                      div_busy;
  logic signed [FIELD_W-1:0] deriv;

  logic                      in_accept;
  logic                      is_mul;
  logic                      out_load;
  logic signed [FIELD_W-1:0] lo_w;
  logic signed [FIELD_W-1:0] hi_w;
  logic signed [FIELD_W-1:0] last_ext;
  logic signed [FIELD_W-1:0] integ_ext;

  assign lo_w      = sat_word(WIDE_W'(low_q), SAT_W);
  assign hi_w      = sat_word(WIDE_W'(high_q), SAT_W);
  assign last_ext  = FIELD_W'(last_q);
  assign integ_ext = FIELD_W'(integ_q);
  assign in_accept = in_valid_i && in_ready_o;

  pidc_mul #(
    .FRAC_BITS (FRAC_BITS),
    .SAT_W     (SAT_W)
  ) u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .stat_o (mul_stat),
    .prod_o (mul_prod)
  );

  pidc_div #(
    .FRAC_BITS (FRAC_BITS),
    .SAT_W     (SAT_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (mul_prod),
    .den_i   (dt_q),
    .busy_o  (div_busy),
    .quot_o  (deriv)
  );

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q   <= PROP_GAIN_RST;
      ki_q   <= '0;
      kd_q   <= '0;
      dt_q   <= STEP_RST;
      rev_q  <= 1'b0;
      pom_q  <= 1'b0;
      low_q  <= OUT_LOW_RST;
      high_q <= OUT_HIGH_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_PROP_GAIN:       kp_q   <= cfg_data_i;
        REG_INTEG_GAIN:      ki_q   <= cfg_data_i;
        REG_DERIV_GAIN:      kd_q   <= cfg_data_i;
        REG_STEP_SECONDS:    dt_q   <= cfg_data_i[STEP_W-1:0];
        REG_REVERSE_ACTION:  rev_q  <= cfg_data_i[0];
        REG_PROP_ON_MEASURE: pom_q  <= cfg_data_i[0];
        REG_OUT_LOW:         low_q  <= cfg_data_i;
        REG_OUT_HIGH:        high_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_DIFF;
        end
      end
      ST_DIFF: state_d = ST_NEG;
      ST_NEG:  state_d = ST_MUL_B;
      ST_MUL_B: begin
        if (mul_stat.done) begin
          state_d = pom_q ? ST_MUL_C : ST_MUL_A;
        end
      end
      ST_MUL_A: begin
        if (mul_stat.done) begin
          state_d = ST_MUL_C;
        end
      end
      ST_MUL_C: begin
        if (mul_stat.done) begin
          state_d = ST_MUL_D;
        end
      end
      ST_MUL_D: begin
        if (mul_stat.done) begin
          state_d = pom_q ? ST_MUL_E : ST_WAIT_DIV;
        end
      end
      ST_MUL_E: begin
        if (mul_stat.done) begin
          state_d = ST_WAIT_DIV;
        end
      end
      ST_WAIT_DIV: begin
        if (!div_busy) begin
          state_d = ST_SUM_PD;
        end
      end
      ST_SUM_PD:  state_d = ST_SUM_PM;
      ST_SUM_PM:  state_d = ST_CLAMP_I;
      ST_CLAMP_I: state_d = ST_SUM_Y;
      ST_SUM_Y:   state_d = ST_OUT;
      ST_OUT: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    in_ready_o     = (state_q == ST_IDLE);
    is_mul         = 1'b0;
    mul_req.mcand  = '0;
    mul_req.mplier = '0;
    case (state_q)
      ST_MUL_B: begin
        is_mul         = 1'b1;
        mul_req.mcand  = dm_q;
        mul_req.mplier = kd_q;
      end
      ST_MUL_A: begin
        is_mul         = 1'b1;
        mul_req.mcand  = err_q;
        mul_req.mplier = kp_q;
      end
      ST_MUL_C: begin
        is_mul         = 1'b1;
        mul_req.mcand  = err_q;
        mul_req.mplier = ki_q;
      end
      ST_MUL_D: begin
        is_mul         = 1'b1;
        mul_req.mcand  = i1_q;
        mul_req.mplier = {1'b0, dt_q};
      end
      ST_MUL_E: begin
        is_mul         = 1'b1;
        mul_req.mcand  = dm_q;
        mul_req.mplier = kp_q;
      end
      default: ;
    endcase
    mul_req.start = is_mul && !issued_q && !mul_stat.busy;
    if (!is_mul || mul_stat.done) begin
      issued_d = 1'b0;
    end else if (mul_req.start) begin
      issued_d = 1'b1;
    end else begin
      issued_d = issued_q;
    end
    div_start = (state_q == ST_MUL_B) && mul_stat.done;
    out_load  = (state_q == ST_OUT) && (!out_valid_q || out_ready_i);
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      issued_q    <= 1'b0;
      out_valid_q <= 1'b0;
      last_q      <= '0;
      integ_q     <= '0;
    end else begin
      state_q     <= state_d;
      issued_q    <= issued_d;
      out_valid_q <= out_valid_d;
      case (state_q)
        ST_DIFF:    last_q  <= SAT_W'(pv_q);
        ST_SUM_PD:  integ_q <= SAT_W'(add_sat(integ_ext, i2_q, SAT_W));
        ST_SUM_PM: begin
          if (pom_q) begin
            integ_q <= SAT_W'(add_sat(integ_ext, pm_q, SAT_W));
          end
        end
        ST_CLAMP_I: integ_q <= SAT_W'(clamp_word(integ_ext, lo_w, hi_w));
        default: ;
      endcase
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      sp_q <= sat_word(WIDE_W'(target_i), SAT_W);
      pv_q <= sat_word(WIDE_W'(measured_i), SAT_W);
    end
    if (out_load) begin
      drive_q <= clamp_word(y_q, lo_w, hi_w);
    end
    case (state_q)
      ST_DIFF: begin
        err_q <= sub_sat(sp_q, pv_q, SAT_W);
        dm_q  <= sub_sat(last_ext, pv_q, SAT_W);
      end
      ST_NEG: begin
        p_q <= '0;
        if (rev_q) begin
          err_q <= sub_sat('0, err_q, SAT_W);
          dm_q  <= sub_sat('0, dm_q, SAT_W);
        end
      end
      ST_MUL_A: begin
        if (mul_stat.done) begin
          p_q <= mul_prod;
        end
      end
      ST_MUL_C: begin
        if (mul_stat.done) begin
          i1_q <= mul_prod;
        end
      end
      ST_MUL_D: begin
        if (mul_stat.done) begin
          i2_q <= mul_prod;
        end
      end
      ST_MUL_E: begin
        if (mul_stat.done) begin
          pm_q <= mul_prod;
        end
      end
      ST_SUM_PD: y_q <= add_sat(p_q, deriv, SAT_W);
      ST_SUM_Y:  y_q <= add_sat(y_q, integ_ext, SAT_W);
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign drive_o     = drive_q;

`ifndef SYNTHESIS
  a_mul_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_req.start |-> !mul_stat.busy)
    else $error("multiplier started while busy");

  a_div_done_before_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SUM_PD) |-> !div_busy)
    else $error("derivative quotient used before divider finished");

  a_integ_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLAMP_I) && (lo_w <= hi_w) |=>
      (integ_ext >= $past(lo_w)) && (integ_ext <= $past(hi_w)))
    else $error("integral outside clamp limits");

  a_drive_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load && (lo_w <= hi_w) |=>
      (drive_o >= $past(lo_w)) && (drive_o <= $past(hi_w)))
    else $error("drive outside clamp limits");
`endif

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for pid_controller_step_core: directed and random samples, each drive
// predicted in signed Q16.16 and compared in order. Depends on pidc_pkg and the core RTL.
module tb;
  import pidc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 600_000;
  localparam longint      WORD_MAX    = 64'sd2147483647;
  localparam longint      WORD_MIN    = -64'sd2147483648;

  logic                      clk_i       = 1'b0;
  logic                      rst_ni      = 1'b0;
  logic                      cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]      cfg_idx_i   = '0;
  logic [FIELD_W-1:0]        cfg_data_i  = '0;
  logic                      in_valid_i  = 1'b0;
  logic                      in_ready_o;
  logic signed [FIELD_W-1:0] target_i    = '0;
  logic signed [FIELD_W-1:0] measured_i  = '0;
  logic                      out_valid_o;
  logic                      out_ready_i = 1'b0;
  logic signed [FIELD_W-1:0] drive_o;

  // Controller settings and loop state as the core should hold them
  longint kp_q;
  longint ki_q;
  longint kd_q;
  longint dt_q;
  bit     reverse_q;
  bit     pom_q;
  longint lo_q;
  longint hi_q;
  longint last_pv_q;
  longint integ_q;

  logic signed [FIELD_W-1:0] drive_pending[$];

  int send_gap_pct  = 0;
  int recv_stall_pct = 0;
  int samples_sent  = 0;
  int drives_checked = 0;
  int reg_writes    = 0;
  int error_count   = 0;
  int unsigned cycle_count = 0;

  pid_controller_step_core u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .target_i   (target_i),
    .measured_i (measured_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .drive_o    (drive_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d drives outstanding", cycle_count,
               drive_pending.size());
      $display("tb: done, errors");
      $finish;
    end
  end

  // Compare each drive leaving the core with the oldest predicted one
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (drive_pending.size() == 0) begin
        $error("drive: expected nothing, got %0d", drive_o);
        error_count++;
      end else begin
        if (drive_o !== drive_pending[0]) begin
          $error("drive: expected %0d, got %0d", drive_pending[0], drive_o);
          error_count++;
        end
        void'(drive_pending.pop_front());
        drives_checked++;
      end
    end
  end

  function automatic longint sat_q(input longint x);
    if (x > WORD_MAX) return WORD_MAX;
    if (x < WORD_MIN) return WORD_MIN;
    return x;
  endfunction

  // Product rounds toward minus infinity
  function automatic longint mul_q(input longint a, input longint b);
    longint p;
    p = a * b;
    return sat_q(p >>> FRAC_BITS_DEF);
  endfunction

  // Quotient truncates toward zero; a zero interval counts as one LSB
  function automatic longint div_q(input longint num, input longint den);
    longint d;
    d = (den > 0) ? den : 64'sd1;
    return sat_q((num * (64'sd1 << FRAC_BITS_DEF)) / d);
  endfunction

  // When the limits cross, values below the low limit give the low limit and all others the high limit
  function automatic longint clamp_q(input longint x, input longint lo, input longint hi);
    if (x < lo) return lo;
    if (hi < x) return hi;
    return x;
  endfunction

  task automatic predict_drive(input logic signed [FIELD_W-1:0] sp_w,
                               input logic signed [FIELD_W-1:0] pv_w);
    longint sp;
    longint pv;
    longint err;
    longint dm;
    longint y;
    sp = sp_w;
    pv = pv_w;
    err = sat_q(sp - pv);
    dm = sat_q(last_pv_q - pv);
    last_pv_q = pv;
    if (reverse_q) begin
      err = sat_q(-err);
      dm = sat_q(-dm);
    end
    y = pom_q ? 64'sd0 : mul_q(err, kp_q);
    y = sat_q(y + div_q(mul_q(dm, kd_q), dt_q));
    integ_q = sat_q(integ_q + mul_q(mul_q(err, ki_q), dt_q));
    if (pom_q) begin
      integ_q = sat_q(integ_q + mul_q(dm, kp_q));
    end
    integ_q = clamp_q(integ_q, lo_q, hi_q);
    y = clamp_q(sat_q(y + integ_q), lo_q, hi_q);
    drive_pending.push_back(y[FIELD_W-1:0]);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [FIELD_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_PROP_GAIN:       kp_q = longint'($signed(data));
      REG_INTEG_GAIN:      ki_q = longint'($signed(data));
      REG_DERIV_GAIN:      kd_q = longint'($signed(data));
      REG_STEP_SECONDS:    dt_q = longint'(data[STEP_W-1:0]);
      REG_REVERSE_ACTION:  reverse_q = data[0];
      REG_PROP_ON_MEASURE: pom_q = data[0];
      REG_OUT_LOW:         lo_q = longint'($signed(data));
      REG_OUT_HIGH:        hi_q = longint'($signed(data));
      default: ;
    endcase
    reg_writes++;
    @(posedge clk_i);
  endtask

  // Send one request; optionally hold off until every drive has come back
  task automatic send_sample(input logic signed [FIELD_W-1:0] sp,
                             input logic signed [FIELD_W-1:0] pv,
                             input bit drain_first);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_gap_pct) gap++;
    if (drain_first) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
      while (drain_first && drive_pending.size() != 0) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    target_i   <= sp;
    measured_i <= pv;
    do @(posedge clk_i); while (!in_ready_o);
    predict_drive(sp, pv);
    samples_sent++;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (drive_pending.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic test_reset_defaults();
    // first sample sees a previous measurement of zero
    send_sample(32'sh0001_0000, 32'sh0000_0000, 1'b0);
    send_sample(32'sh7fff_ffff, 32'sh8000_0000, 1'b0);
    send_sample(32'sh8000_0000, 32'sh7fff_ffff, 1'b0);
    wait_drained();
  endtask

  task automatic test_field_extremes();
    write_reg(REG_PROP_GAIN, 32'h7fff_ffff);
    write_reg(REG_INTEG_GAIN, 32'h8000_0000);
    write_reg(REG_DERIV_GAIN, 32'h7fff_ffff);
    write_reg(REG_STEP_SECONDS, 32'h8000_0001);  // bit 31 is not part of the interval
    write_reg(REG_REVERSE_ACTION, 32'h0000_0000);
    write_reg(REG_PROP_ON_MEASURE, 32'h0000_0000);
    write_reg(REG_OUT_LOW, 32'h8000_0000);
    write_reg(REG_OUT_HIGH, 32'h7fff_ffff);
    send_sample(32'sh0000_0000, 32'sh7fff_ffff, 1'b0);
    send_sample(32'sh0000_0000, 32'sh8000_0000, 1'b0);
    send_sample(32'sh7fff_ffff, 32'sh7fff_ffff, 1'b0);
    send_sample(32'shffff_ffff, 32'sh0000_0001, 1'b0);
    wait_drained();
    write_reg(REG_DERIV_GAIN, 32'h8000_0000);
    write_reg(REG_PROP_GAIN, 32'hffff_8000);
    write_reg(REG_STEP_SECONDS, 32'h7fff_ffff);
    send_sample(32'sh8000_0000, 32'sh0000_0000, 1'b0);
    send_sample(32'sh0001_8000, 32'shfffe_0000, 1'b0);
    wait_drained();
  endtask

  task automatic test_direction_modes();
    write_reg(REG_PROP_GAIN, 32'h0002_0000);
    write_reg(REG_INTEG_GAIN, 32'h0000_8000);
    write_reg(REG_DERIV_GAIN, 32'h0000_4000);
    write_reg(REG_STEP_SECONDS, 32'd6554);
    write_reg(REG_OUT_LOW, 32'hfc18_0000);
    write_reg(REG_OUT_HIGH, 32'h03e8_0000);
    for (int mode = 0; mode < 4; mode++) begin
      write_reg(REG_REVERSE_ACTION, 32'(mode & 1));
      write_reg(REG_PROP_ON_MEASURE, 32'(mode >> 1));
      send_sample(32'sh0005_0000, 32'sh0001_0000, 1'b0);
      send_sample(32'sh0005_0000, 32'sh0003_2000, 1'b0);
      wait_drained();
    end
  endtask

  task automatic test_crossed_limits();
    write_reg(REG_OUT_LOW, 32'h0005_0000);
    write_reg(REG_OUT_HIGH, 32'hfffb_0000);
    send_sample(32'sh0000_0000, 32'sh0064_0000, 1'b0);
    send_sample(32'sh0000_0000, 32'sh0000_0000, 1'b0);
    send_sample(32'sh0064_0000, 32'sh0000_0000, 1'b0);
    wait_drained();
  endtask

  task automatic test_zero_interval();
    write_reg(REG_OUT_LOW, 32'h8000_0000);
    write_reg(REG_OUT_HIGH, 32'h7fff_ffff);
    write_reg(REG_DERIV_GAIN, 32'h0001_0000);
    write_reg(REG_STEP_SECONDS, 32'h0000_0000);
    send_sample(32'sh0000_0000, 32'sh0000_0003, 1'b0);
    send_sample(32'sh0000_0000, 32'shffff_fff0, 1'b0);
    wait_drained();
  endtask

  function automatic logic [FIELD_W-1:0] pick_gain();
    case ($urandom_range(6))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h0000_0000;
      3:       return $urandom;
      default: return 32'($urandom_range(1 << 19)) - 32'(1 << 18);
    endcase
  endfunction

  task automatic randomize_settings();
    logic [FIELD_W-1:0] lo;
    logic [FIELD_W-1:0] hi;
    logic [FIELD_W-1:0] dt;
    logic [FIELD_W-1:0] tmp;
    case ($urandom_range(5))
      0:       dt = 32'h0000_0001;
      1:       dt = 32'h7fff_ffff;
      2:       dt = $urandom;
      default: dt = 32'($urandom_range(1, 1 << 17));
    endcase
    dt[31] = 1'($urandom_range(1));
    case ($urandom_range(7))
      0: begin
        lo = 32'h8000_0000;
        hi = 32'h7fff_ffff;
      end
      1: begin
        lo = $urandom;
        hi = $urandom;
      end
      2: begin
        lo = $urandom;
        hi = $urandom;
        if ($signed(lo) > $signed(hi)) begin
          tmp = lo;
          lo = hi;
          hi = tmp;
        end
      end
      default: begin
        lo = -32'($urandom_range(1, 1 << 24));
        hi = 32'($urandom_range(1, 1 << 24));
      end
    endcase
    wait_drained();
    write_reg(REG_PROP_GAIN, pick_gain());
    write_reg(REG_INTEG_GAIN, pick_gain());
    write_reg(REG_DERIV_GAIN, pick_gain());
    write_reg(REG_STEP_SECONDS, dt);
    write_reg(REG_REVERSE_ACTION, $urandom);
    write_reg(REG_PROP_ON_MEASURE, $urandom);
    write_reg(REG_OUT_LOW, lo);
    write_reg(REG_OUT_HIGH, hi);
  endtask

  // Mostly a drifting plant with a held setpoint, plus full-range noise and extremes
  task automatic test_random_phase(input int gap_pct, input int stall_pct, input int count);
    logic signed [FIELD_W-1:0] sp;
    logic signed [FIELD_W-1:0] pv;
    sp = 32'sh0002_0000;
    pv = '0;
    send_gap_pct   = gap_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) randomize_settings();
      case ($urandom_range(9))
        0:       sp = $urandom;
        1:       sp = 32'($urandom_range(1 << 20)) - 32'(1 << 19);
        default: ;
      endcase
      case ($urandom_range(9))
        0:       pv = $urandom;
        1:       pv = 32'sh8000_0000;
        2:       pv = 32'sh7fff_ffff;
        default: pv = pv + 32'($urandom_range(1 << 18)) - 32'(1 << 17);
      endcase
      send_sample(sp, pv, $urandom_range(49) == 0);
    end
    wait_drained();
  endtask

  initial begin
    kp_q      = longint'(PROP_GAIN_RST);
    ki_q      = 0;
    kd_q      = 0;
    dt_q      = longint'(STEP_RST);
    reverse_q = 1'b0;
    pom_q     = 1'b0;
    lo_q      = longint'(OUT_LOW_RST);
    hi_q      = longint'(OUT_HIGH_RST);
    last_pv_q = 0;
    integ_q   = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_field_extremes();
    test_direction_modes();
    test_crossed_limits();
    test_zero_interval();
    test_random_phase(10, 52, 170);
    test_random_phase(52, 10, 170);
    test_random_phase(0, 0, 160);

    while (drive_pending.size() != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
    $display("summary: %0d samples and %0d register writes, directed corners and three",
             samples_sent, reg_writes);
    $display("summary: random idling phases; %0d drives compared, %0d mismatches",
             drives_checked, error_count);
    if (error_count == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
